@@ rtl/core/prl_pkg.sv @@
`timescale 1ns / 1ps

package prl_pkg;

    // fixed field widths of a result word
    localparam int FIELD_BITS = 20;
    localparam int TOTAL_BITS = 32;
    localparam int CH_BITS    = 8;
    localparam int PAR_BITS   = 2;

    localparam logic [FIELD_BITS-1:0] FIELD_MAX       = {FIELD_BITS{1'b1}};
    localparam logic [FIELD_BITS-1:0] MAX_PAGES_RESET = FIELD_BITS'(99999);
    localparam int                    PAGE_BITS_DEF   = 20;

    // characters of the list syntax
    localparam logic [CH_BITS-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_BITS-1:0] CH_HYPHEN = 8'h2d;
    localparam logic [CH_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_BITS-1:0] CH_E_LO   = 8'h65;
    localparam logic [CH_BITS-1:0] CH_E_UP   = 8'h45;
    localparam logic [CH_BITS-1:0] CH_O_LO   = 8'h6f;
    localparam logic [CH_BITS-1:0] CH_O_UP   = 8'h4f;

    // parity codes
    localparam logic [PAR_BITS-1:0] PAR_ALL  = 2'd0;
    localparam logic [PAR_BITS-1:0] PAR_ODD  = 2'd1;
    localparam logic [PAR_BITS-1:0] PAR_EVEN = 2'd2;

    // parse phases
    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_NUM1    = 3'd1;
    localparam logic [2:0] PH_AFTER1  = 3'd2;
    localparam logic [2:0] PH_PARONLY = 3'd3;
    localparam logic [2:0] PH_HYPH    = 3'd4;
    localparam logic [2:0] PH_NUM2    = 3'd5;
    localparam logic [2:0] PH_SEP     = 3'd6;

    // output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef struct packed {
        logic [FIELD_BITS-1:0] first_page;
        logic [FIELD_BITS-1:0] last_page;
        logic [PAR_BITS-1:0]   parity;
        logic [FIELD_BITS-1:0] pages_counted;
        logic [TOTAL_BITS-1:0] total_pages;
        logic                  list_end;
    } result_t;

endpackage

@@ rtl/core/prl_core.sv @@
`timescale 1ns / 1ps

module prl_core
    import prl_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  logic [CH_BITS-1:0]    ch,
    input  logic [FIELD_BITS-1:0] max_pages,
    output logic                  rng_valid,
    output result_t               rng_word,
    output logic                  fin_valid,
    output result_t               fin_word
);

    localparam int MW   = (PAGE_BITS > FIELD_BITS) ? PAGE_BITS : FIELD_BITS;
    localparam int SW   = MW + 2;
    localparam int SUMW = ((SW > TOTAL_BITS) ? SW : TOTAL_BITS) + 1;
    localparam logic [PAGE_BITS-1:0] NUM_MAX = {PAGE_BITS{1'b1}};

    logic [2:0]            phase_reg, phase_next;
    logic [PAGE_BITS-1:0]  start_reg, start_next;
    logic [PAGE_BITS-1:0]  end_reg, end_next;
    logic [PAR_BITS-1:0]   par_reg, par_next;
    logic                  open_reg, open_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic                  seen_reg, seen_next;

    logic                  digit;
    logic [3:0]            dval;
    logic [PAR_BITS-1:0]   mark;
    logic                  is_hyph;
    logic                  is_nul;
    logic                  sep;

    logic signed [SW-1:0]  mx, a0, bfix, b0, a1, b1, lo, hi, lo_c, hi_c, diff;
    logic                  eff_open, asc, in_range, empty;
    logic [SW-1:0]         cnt;
    logic [SUMW-1:0]       sum;
    logic [TOTAL_BITS-1:0] total_after;

    function automatic logic [PAGE_BITS-1:0] add_digit(input logic [PAGE_BITS-1:0] v,
                                                        input logic [3:0] d);
        logic [PAGE_BITS+3:0] r;
        r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + (PAGE_BITS+4)'(d);
        return (r > (PAGE_BITS+4)'(NUM_MAX)) ? NUM_MAX : r[PAGE_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] clamp_field(input logic signed [SW-1:0] x);
        logic [FIELD_BITS-1:0] r;
        if (x < 0) begin
            r = '0;
        end else if (x > $signed(SW'(FIELD_MAX))) begin
            r = FIELD_MAX;
        end else begin
            r = x[FIELD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] to_even(input logic signed [SW-1:0] x);
        return x & ~SW'(1);
    endfunction

    function automatic logic signed [SW-1:0] to_odd(input logic signed [SW-1:0] x);
        return x | SW'(1);
    endfunction

    always_comb begin
        digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
        dval    = digit ? ch[3:0] : 4'd0;
        is_hyph = (ch == CH_HYPHEN);
        is_nul  = (ch == CH_NUL);
        if (ch == CH_E_LO || ch == CH_E_UP) begin
            mark = PAR_EVEN;
        end else if (ch == CH_O_LO || ch == CH_O_UP) begin
            mark = PAR_ODD;
        end else begin
            mark = PAR_ALL;
        end
    end

    // phase step
    always_comb begin
        phase_next = phase_reg;
        start_next = start_reg;
        end_next   = end_reg;
        par_next   = par_reg;
        open_next  = open_reg;
        sep        = 1'b0;
        case (phase_reg)
            PH_NUM1: begin
                if (digit) begin
                    start_next = add_digit(start_reg, dval);
                end else if (mark != PAR_ALL) begin
                    par_next   = mark;
                    phase_next = PH_AFTER1;
                end else if (is_hyph) begin
                    phase_next = PH_HYPH;
                end else begin
                    end_next  = start_reg;
                    open_next = 1'b0;
                    sep       = 1'b1;
                end
            end
            PH_AFTER1: begin
                if (is_hyph) begin
                    phase_next = PH_HYPH;
                end else begin
                    end_next  = start_reg;
                    open_next = 1'b0;
                    sep       = 1'b1;
                end
            end
            PH_PARONLY: begin
                start_next = PAGE_BITS'(1);
                if (is_hyph) begin
                    phase_next = PH_HYPH;
                end else begin
                    open_next = 1'b0;
                    sep       = 1'b1;
                end
            end
            PH_HYPH: begin
                if (mark != PAR_ALL) begin
                    par_next   = mark;
                    open_next  = 1'b1;
                    phase_next = PH_SEP;
                end else if (digit) begin
                    end_next   = PAGE_BITS'(dval);
                    open_next  = 1'b0;
                    phase_next = PH_NUM2;
                end else begin
                    open_next = 1'b1;
                    sep       = 1'b1;
                end
            end
            PH_NUM2: begin
                if (digit) begin
                    end_next = add_digit(end_reg, dval);
                end else if (mark != PAR_ALL) begin
                    par_next   = mark;
                    phase_next = PH_SEP;
                end else begin
                    sep = 1'b1;
                end
            end
            PH_SEP: begin
                sep = 1'b1;
            end
            default: begin
                phase_next = PH_START;
                start_next = '0;
                end_next   = '0;
                par_next   = PAR_ALL;
                open_next  = 1'b0;
                if (!is_nul) begin
                    if (digit) begin
                        start_next = PAGE_BITS'(dval);
                        phase_next = PH_NUM1;
                    end else if (mark != PAR_ALL) begin
                        par_next   = mark;
                        phase_next = PH_PARONLY;
                    end else if (is_hyph) begin
                        start_next = PAGE_BITS'(1);
                        phase_next = PH_HYPH;
                    end
                end
            end
        endcase
        if (sep) begin
            phase_next = PH_START;
        end
    end

    // range finish, from the values the token closes with
    always_comb begin
        mx = $signed({{(SW-FIELD_BITS){1'b0}}, max_pages});
        a0 = (phase_reg == PH_PARONLY) ? SW'(1) : $signed({{(SW-PAGE_BITS){1'b0}}, start_reg});
        if (phase_reg == PH_NUM1 || phase_reg == PH_AFTER1) begin
            bfix = $signed({{(SW-PAGE_BITS){1'b0}}, start_reg});
        end else if (phase_reg == PH_PARONLY) begin
            bfix = mx;
        end else begin
            bfix = $signed({{(SW-PAGE_BITS){1'b0}}, end_reg});
        end
        if (phase_reg == PH_HYPH) begin
            eff_open = 1'b1;
        end else if (phase_reg == PH_NUM1 || phase_reg == PH_AFTER1 ||
                     phase_reg == PH_PARONLY) begin
            eff_open = 1'b0;
        end else begin
            eff_open = open_reg;
        end
        b0  = eff_open ? ((mx < a0) ? a0 : mx) : bfix;
        asc = (b0 >= a0);
        if (par_reg == PAR_EVEN) begin
            a1 = asc ? to_even(a0 + SW'(1)) : to_even(a0);
            b1 = asc ? to_even(b0) : to_even(b0 + SW'(1));
        end else if (par_reg == PAR_ODD) begin
            a1 = asc ? to_odd(a0) : to_odd(a0 - SW'(1));
            b1 = asc ? to_odd(b0 - SW'(1)) : to_odd(b0);
        end else begin
            a1 = a0;
            b1 = b0;
        end
        empty    = (a1 <= 0) && (b1 <= 0);
        lo       = (a1 < b1) ? a1 : b1;
        hi       = (a1 < b1) ? b1 : a1;
        in_range = !(((mx > 0) && (lo > mx)) || (hi < 1));
        lo_c     = (lo < 1) ? SW'(1) : lo;
        hi_c     = ((mx > 0) && (hi > mx)) ? mx : hi;
        diff     = hi_c - lo_c;
        if (!in_range) begin
            cnt = '0;
        end else if (par_reg == PAR_ALL) begin
            cnt = diff + SW'(1);
        end else if (hi_c >= lo_c) begin
            cnt = (diff + SW'(2)) >> 1;
        end else begin
            cnt = '0;
        end
        sum = SUMW'(total_reg) + SUMW'(cnt);
        if (sum[SUMW-1:TOTAL_BITS] != '0) begin
            total_after = {TOTAL_BITS{1'b1}};
        end else begin
            total_after = sum[TOTAL_BITS-1:0];
        end
    end

    always_comb begin
        rng_valid              = fire && sep && !empty;
        rng_word.first_page    = clamp_field(a1);
        rng_word.last_page     = clamp_field(b1);
        rng_word.parity        = par_reg;
        rng_word.pages_counted = (cnt > SW'(FIELD_MAX)) ? FIELD_MAX : cnt[FIELD_BITS-1:0];
        rng_word.total_pages   = total_after;
        rng_word.list_end      = 1'b0;

        fin_valid              = fire && is_nul;
        fin_word.first_page    = '0;
        fin_word.last_page     = '0;
        fin_word.parity        = PAR_ALL;
        fin_word.pages_counted = '0;
        fin_word.total_pages   = (sep && !empty) ? total_after : total_reg;
        if (!seen_reg) begin
            fin_word.total_pages = TOTAL_BITS'(max_pages);
        end
        fin_word.list_end      = 1'b1;

        total_next = (sep && !empty) ? total_after : total_reg;
        seen_next  = seen_reg | !is_nul;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            start_reg <= '0;
            end_reg   <= '0;
            par_reg   <= PAR_ALL;
            open_reg  <= 1'b0;
            total_reg <= '0;
            seen_reg  <= 1'b0;
        end else if (fire) begin
            if (is_nul) begin
                // end of list: everything back to its reset value
                phase_reg <= PH_START;
                start_reg <= '0;
                end_reg   <= '0;
                par_reg   <= PAR_ALL;
                open_reg  <= 1'b0;
                total_reg <= '0;
                seen_reg  <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                start_reg <= start_next;
                end_reg   <= end_next;
                par_reg   <= par_next;
                open_reg  <= open_next;
                total_reg <= total_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule

@@ rtl/core/prl_outq.sv @@
`timescale 1ns / 1ps

module prl_outq
    import prl_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push0,
    input  result_t word0,
    input  logic    push1,
    input  result_t word1,
    input  logic    pop,
    output logic    head_valid,
    output result_t head_word,
    output logic    has_room
);

    result_t             q_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OQ_PTR_W-1:0] wr_idx1;
    logic [OQ_CNT_W-1:0] count_reg, count_next;

    assign wr_idx1    = wr_ptr_reg + OQ_PTR_W'(push0);
    assign head_valid = (count_reg != '0);
    assign head_word  = q_mem[rd_ptr_reg];
    // room for the two words one character can cause
    assign has_room   = (count_reg <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign count_next = count_reg + OQ_CNT_W'(push0) + OQ_CNT_W'(push1) - OQ_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push0) begin
            q_mem[wr_ptr_reg] <= word0;
        end
        if (push1) begin
            q_mem[wr_idx1] <= word1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + OQ_PTR_W'(push0) + OQ_PTR_W'(push1);
            rd_ptr_reg <= rd_ptr_reg + OQ_PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/page_range_list_parser.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_ch (one character, 0 ends the list)
// m_        out        m_valid / m_ready    first_page, last_page, parity,
//                                           pages_counted, total_pages, list_end
// cfg_      in         cfg_we               cfg_wdata (max_pages)
//
// one character per cycle while the queue has room: each character is held in the input
// register, then the parse step and range count run on it and write up to two words into a
// four-entry output queue, whose head drives m_.
// s_ready drops only while the queue has fewer than two free entries.
// synchronous active-low reset clears the parse state, the running total and the queue.

module page_range_list_parser
    import prl_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [FIELD_BITS-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CH_BITS-1:0]    s_ch,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FIELD_BITS-1:0] m_first_page,
    output logic [FIELD_BITS-1:0] m_last_page,
    output logic [PAR_BITS-1:0]   m_parity,
    output logic [FIELD_BITS-1:0] m_pages_counted,
    output logic [TOTAL_BITS-1:0] m_total_pages,
    output logic                  m_list_end
);

    logic [FIELD_BITS-1:0] max_pages_reg;
    logic                  in_valid_reg;
    logic [CH_BITS-1:0]    in_ch_reg;
    logic                  fire;
    logic                  has_room;
    logic                  rng_valid, fin_valid;
    result_t               rng_word, fin_word, head_word;

    assign fire    = in_valid_reg && has_room;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pages_reg <= MAX_PAGES_RESET;
            in_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_pages_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_ch_reg <= s_ch;
        end
    end

    prl_core #(
        .PAGE_BITS (PAGE_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .ch        (in_ch_reg),
        .max_pages (max_pages_reg),
        .rng_valid (rng_valid),
        .rng_word  (rng_word),
        .fin_valid (fin_valid),
        .fin_word  (fin_word)
    );

    prl_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push0      (rng_valid),
        .word0      (rng_word),
        .push1      (fin_valid),
        .word1      (fin_word),
        .pop        (m_valid && m_ready),
        .head_valid (m_valid),
        .head_word  (head_word),
        .has_room   (has_room)
    );

    assign m_first_page    = head_word.first_page;
    assign m_last_page     = head_word.last_page;
    assign m_parity        = head_word.parity;
    assign m_pages_counted = head_word.pages_counted;
    assign m_total_pages   = head_word.total_pages;
    assign m_list_end      = head_word.list_end;

endmodule
